### hdl/rrs_pkg.sv
// Shared types, sizes and beat layout for the recency request stack.
`timescale 1ns / 1ps

package rrs_pkg;

    // Stack depth and longest path accepted on a push.
    localparam int CAPACITY = 16;
    localparam int MAX_PATH = 1024;

    // Field widths.
    localparam int GEN_W    = 32;
    localparam int INDEX_W  = 16;
    localparam int ASPECT_W = 64;
    localparam int PLEN_W   = 11;
    localparam int HANDLE_W = 32;

    // Fill count holds 0 to CAPACITY inclusive.
    localparam int FILL_W = $clog2(CAPACITY + 1);

    // Beat layout of tdata on both channels, lowest field first.
    localparam int GEN_LO    = 0;
    localparam int INDEX_LO  = GEN_LO + GEN_W;
    localparam int FOLDER_LO = INDEX_LO + INDEX_W;
    localparam int ASPECT_LO = FOLDER_LO + 1;
    localparam int PLEN_LO   = ASPECT_LO + ASPECT_W;
    localparam int HANDLE_LO = PLEN_LO + PLEN_W;
    localparam int FIELDS_W  = HANDLE_LO + HANDLE_W;
    localparam int TDATA_W   = ((FIELDS_W + 7) / 8) * 8;

    // Command carried on the input tuser.
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TAKE = 1'b1
    } cmd_t;

    // One stored request.
    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic                folder;
        logic [ASPECT_W-1:0] aspect;
        logic [PLEN_W-1:0]   path_length;
        logic [HANDLE_W-1:0] path_handle;
    } entry_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic               push;
        logic               pop;
        logic [INDEX_W-1:0] key;
    } cell_ctrl_t;

endpackage

### hdl/rrs_cell.sv
// One storage cell of the request stack chain.
`timescale 1ns / 1ps

module rrs_cell
    import rrs_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       valid_i,   // cell lies below the fill count
    input  logic       hit_i,     // a newer cell already holds the key
    input  entry_t     newer_i,   // neighbour towards the top (or the new entry)
    input  entry_t     older_i,   // neighbour towards the bottom
    output entry_t     entry_o,
    output logic       hit_o
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;

    // Key compare; the hit flag ripples towards the oldest cell.
    assign match   = valid_i && (entry_reg.index == ctrl.key);
    assign hit_o   = hit_i || match;
    assign entry_o = entry_reg;

    // A push moves every cell down to and including the duplicate; a take
    // moves every cell up by one.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.push && !hit_i) begin
            entry_next = newer_i;
        end else if (ctrl.pop) begin
            entry_next = older_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### hdl/recency_request_stack.sv
// Top level of the recency request stack: handshake, fill count and cell chain.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one command per beat: s_tuser selects a push (0)
// or a take (1), and s_tdata carries the request. The master channel gives
// one result beat per command: m_tuser is the ok flag, m_tdata the taken
// entry (all zero after a push or a take from an empty stack).
// A push is kept only when its generation equals the generation register
// and its path length lies in 1 to MAX_PATH; a stored entry with the same
// item index is removed first, and when the stack is full the oldest entry
// is dropped. Writing cfg_wr_en/cfg_wr_data loads the generation register
// and empties the stack.
// The result beat of an accepted command is registered and appears in the cycle after it.
// Every cell compares and shifts in the same cycle, so a command is taken
// every cycle while the result register is free or being emptied.
// When the receiver stalls, the result waits in the output register and
// s_tready drops until it is taken.
// Reset empties the stack, clears the generation register and the output valid flag.
module recency_request_stack
    import rrs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration
    input  logic               cfg_wr_en,
    input  logic [GEN_W-1:0]   cfg_wr_data,  // current_generation
    // Command channel
    input  logic               s_tvalid,
    output logic               s_tready,
    // tdata: req_generation, item_index, is_folder, aspect_bits,
    //        path_length, path_handle, zero padding
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tuser,      // cmd
    // Result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    // tdata: out_generation, out_index, out_folder, out_aspect_bits,
    //        out_path_length, out_path_handle, zero padding
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser       // ok
);

    logic [GEN_W-1:0]   cur_gen_reg;
    logic [FILL_W-1:0]  fill_count_reg;
    logic [FILL_W-1:0]  fill_count_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [TDATA_W-1:0] m_tdata_next;
    logic               m_tuser_reg;
    logic               m_tuser_next;

    logic               accept;
    cmd_t               cmd;
    logic [GEN_W-1:0]   req_gen;
    logic [PLEN_W-1:0]  req_plen;
    entry_t             new_entry;
    logic               push_ok;
    logic               take_ok;
    logic               hit_any;
    cell_ctrl_t         ctrl;

    entry_t             cell_entry [CAPACITY];
    logic               cell_hit   [CAPACITY];

    // Handshake: a new beat is taken while the result register is free
    // or emptying in this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Unpack the command beat.
    assign cmd                   = cmd_t'(s_tuser);
    assign req_gen               = s_tdata[GEN_LO +: GEN_W];
    assign req_plen              = s_tdata[PLEN_LO +: PLEN_W];
    assign new_entry.index       = s_tdata[INDEX_LO +: INDEX_W];
    assign new_entry.folder      = s_tdata[FOLDER_LO];
    assign new_entry.aspect      = s_tdata[ASPECT_LO +: ASPECT_W];
    assign new_entry.path_length = req_plen;
    assign new_entry.path_handle = s_tdata[HANDLE_LO +: HANDLE_W];

    // Push admission and take qualification.
    assign push_ok = accept && (cmd == CMD_PUSH) && (req_gen == cur_gen_reg)
                     && (req_plen != '0) && (32'(req_plen) <= 32'(MAX_PATH));
    assign take_ok = accept && (cmd == CMD_TAKE) && (fill_count_reg != '0);

    assign ctrl.push = push_ok;
    assign ctrl.pop  = take_ok;
    assign ctrl.key  = new_entry.index;

    // Chain of cells; cell 0 holds the newest entry.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam int OLDER = (k < CAPACITY - 1) ? k + 1 : k;

        entry_t newer;
        logic   hit_in;
        logic   valid;

        if (k == 0) begin : g_top
            assign newer  = new_entry;
            assign hit_in = 1'b0;
        end else begin : g_inner
            assign newer  = cell_entry[k-1];
            assign hit_in = cell_hit[k-1];
        end

        assign valid = fill_count_reg > FILL_W'(k);

        rrs_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .valid_i (valid),
            .hit_i   (hit_in),
            .newer_i (newer),
            .older_i (cell_entry[OLDER]),
            .entry_o (cell_entry[k]),
            .hit_o   (cell_hit[k])
        );
    end

    assign hit_any = cell_hit[CAPACITY-1];

    // Fill count: a duplicate or a full stack keeps the count on a push.
    always_comb begin
        fill_count_next = fill_count_reg;
        if (cfg_wr_en) begin
            fill_count_next = '0;
        end else if (push_ok) begin
            if (!hit_any && (fill_count_reg != FILL_W'(CAPACITY))) begin
                fill_count_next = fill_count_reg + FILL_W'(1);
            end
        end else if (take_ok) begin
            fill_count_next = fill_count_reg - FILL_W'(1);
        end
    end

    // Result beat: the newest entry on a successful take, else zeros.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = push_ok || take_ok;
            if (take_ok) begin
                m_tdata_next[GEN_LO +: GEN_W]       = cur_gen_reg;
                m_tdata_next[INDEX_LO +: INDEX_W]   = cell_entry[0].index;
                m_tdata_next[FOLDER_LO]             = cell_entry[0].folder;
                m_tdata_next[ASPECT_LO +: ASPECT_W] = cell_entry[0].aspect;
                m_tdata_next[PLEN_LO +: PLEN_W]     = cell_entry[0].path_length;
                m_tdata_next[HANDLE_LO +: HANDLE_W] = cell_entry[0].path_handle;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_gen_reg    <= '0;
            fill_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cur_gen_reg <= cfg_wr_data;
            end
            fill_count_reg <= fill_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(CAPACITY))
        else $error("fill count above capacity");

    // A generation write empties the stack.
    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (fill_count_reg == '0))
        else $error("stack not empty after generation write");

    // A take from an empty stack reports not ok.
    a_take_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd == CMD_TAKE) && (fill_count_reg == '0))
        |=> (m_tvalid && !m_tuser))
        else $error("take from empty stack reported ok");

    // A rejected push leaves the stack depth unchanged.
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd == CMD_PUSH) && !push_ok && !cfg_wr_en)
        |=> $stable(fill_count_reg))
        else $error("rejected push changed the stack");

    // Every accepted command leaves a result beat behind.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted command produced no result");

endmodule
